### rtl/pct_pkg.sv
// Package: shared types, constants and helpers of the pulse completion tracker.
`timescale 1ns / 1ps
package pct_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int NUM_SOURCES = 32;
    localparam int SLOT_LIMIT  = (NUM_SOURCES < 32) ? NUM_SOURCES : 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_TOUCH      = 3'd0;
    localparam logic [2:0] OP_TIMING     = 3'd1;
    localparam logic [2:0] OP_PARTIAL    = 3'd2;
    localparam logic [2:0] OP_SRC_DONE   = 3'd3;
    localparam logic [2:0] OP_REGISTER   = 3'd4;
    localparam logic [2:0] OP_UNREGISTER = 3'd5;

    localparam logic [1:0] KIND_RELEASED = 2'd0;
    localparam logic [1:0] KIND_GRANTED  = 2'd1;
    localparam logic [1:0] KIND_NO_SLOT  = 2'd2;
    localparam logic [1:0] KIND_FULL     = 2'd3;

    localparam int FLAG_PARTIAL = 0;
    localparam int FLAG_DUP     = 1;
    localparam int FLAG_TIMING  = 2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] pid;
        logic [7:0]  dup_index;
        logic [4:0]  source_slot;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] pid;
        logic [7:0]  dup_index;
        logic        partial;
        logic        duplicate;
        logic        missing_timing;
        logic [4:0]  slot;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [63:0] pid;
        logic [7:0]  dup;
        logic [31:0] pending;
        logic [2:0]  flags;
    } t_entry;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_REL_SCAN,
        S_REL_STEP,
        S_UNREG
    } t_state;

    function automatic logic [31:0] slot_bit(input logic [4:0] slot);
        logic [31:0] b;
        b = '0;
        if (int'(slot) < SLOT_LIMIT) begin
            b = 32'd1 << slot;
        end
        return b;
    endfunction

endpackage

### rtl/pct_front.sv
// Front end: accepts command items and queues them for the back end.
`timescale 1ns / 1ps
module pct_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pct_pkg::t_item      i_item,
    input  logic                i_pop,
    output pct_pkg::t_queue_head o_head
);
    import pct_pkg::*;

    t_item      r_q [QUEUE_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign busy   = (r_cnt == 2'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign pop    = i_pop && (r_cnt != 2'd0);
    assign o_head = '{valid: (r_cnt != 2'd0), item: r_q[r_rd]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule

### rtl/pct_back.sv
// Back end: pulse table, source mask and the sequencer that walks the table.
`timescale 1ns / 1ps
module pct_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pct_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_strobe,
    output pct_pkg::t_result     o_result
);
    import pct_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_item              r_item, n_item;
    logic               r_hit, n_hit;
    logic               r_free_ok, n_free_ok;
    logic [IDX_W-1:0]   r_tgt, n_tgt;
    logic [31:0]        r_src, n_src;
    logic [71:0]        r_rel_key, n_rel_key;
    logic               r_flag_earlier, n_flag_earlier;
    logic               r_min_ok, n_min_ok;
    logic [IDX_W-1:0]   r_min_idx, n_min_idx;
    logic [71:0]        r_min_key, n_min_key;
    logic               r_have_pend, n_have_pend;
    t_result            r_pend, n_pend;
    t_result            r_out, n_out;
    logic               r_strobe, n_strobe;

    logic               r_valid [TABLE_DEPTH];
    t_entry             r_tab   [TABLE_DEPTH];

    logic [IDX_W-1:0]   rd_addr;
    t_entry             rd;
    logic               rd_valid;
    logic [71:0]        rd_key;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               clr_en;
    logic               scan_end;
    logic [31:0]        bit_m;
    t_entry             mod;
    logic               grant_ok;
    logic [4:0]         grant;
    logic               unreg_release;

    always_comb begin
        unique case (r_state)
            S_APPLY:    rd_addr = r_tgt;
            S_REL_STEP: rd_addr = r_min_idx;
            default:    rd_addr = r_idx;
        endcase
    end

    assign rd       = r_tab[rd_addr];
    assign rd_valid = r_valid[rd_addr];
    assign rd_key   = {rd.pid, rd.dup};
    assign scan_end = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign bit_m    = slot_bit(r_item.source_slot);
    assign o_pop    = (r_state == S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_comb begin
        grant_ok = 1'b0;
        grant    = '0;
        for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
            if (!r_src[i]) begin
                grant_ok = 1'b1;
                grant    = 5'(i);
            end
        end
    end

    always_comb begin
        mod = r_hit ? rd : '{pid: r_item.pid, dup: r_item.dup_index,
                             pending: r_src, flags: {1'b0, (r_item.dup_index != 8'd0), 1'b0}};
        unique case (r_item.opcode)
            OP_TIMING:   mod.flags[FLAG_TIMING]  = 1'b1;
            OP_PARTIAL:  mod.flags[FLAG_PARTIAL] = 1'b1;
            OP_SRC_DONE: mod.pending             = mod.pending & ~bit_m;
            default:     mod.pending             = mod.pending;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.opcode <= OP_SRC_DONE) begin
                        n_state = S_LOOK;
                    end else if (i_head.item.opcode == OP_UNREGISTER) begin
                        n_state = S_UNREG;
                    end
                end
            end
            S_LOOK: begin
                if (scan_end) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if ((r_hit || r_free_ok) && r_item.opcode == OP_SRC_DONE &&
                    mod.pending == 32'd0) begin
                    n_state = S_REL_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REL_SCAN: begin
                if (scan_end) begin
                    n_state = S_REL_STEP;
                end
            end
            S_REL_STEP: n_state = r_min_ok ? S_REL_SCAN : S_IDLE;
            S_UNREG: begin
                if (scan_end) begin
                    n_state = unreg_release ? S_REL_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx          = r_idx;
        n_item         = r_item;
        n_hit          = r_hit;
        n_free_ok      = r_free_ok;
        n_tgt          = r_tgt;
        n_src          = r_src;
        n_rel_key      = r_rel_key;
        n_flag_earlier = r_flag_earlier;
        n_min_ok       = r_min_ok;
        n_min_idx      = r_min_idx;
        n_min_key      = r_min_key;
        n_have_pend    = r_have_pend;
        n_pend         = r_pend;
        n_out          = r_out;
        n_strobe       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = rd_addr;
        wr_data        = rd;
        clr_en         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
                n_min_ok  = 1'b0;
                if (i_head.valid) begin
                    n_item = i_head.item;
                    if (i_head.item.opcode == OP_TIMING) begin
                        n_item.dup_index = 8'd0;
                    end
                    if (i_head.item.opcode == OP_REGISTER) begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                        n_out.last = 1'b1;
                        if (grant_ok) begin
                            n_out.kind = KIND_GRANTED;
                            n_out.slot = grant;
                            n_src      = r_src | (32'd1 << grant);
                        end else begin
                            n_out.kind = KIND_NO_SLOT;
                        end
                    end
                end
            end
            S_LOOK: begin
                n_idx = r_idx + IDX_W'(1);
                if (rd_valid && rd.pid == r_item.pid &&
                    rd.dup == r_item.dup_index) begin
                    n_hit = 1'b1;
                    n_tgt = r_idx;
                end else if (!rd_valid && !r_free_ok && !r_hit) begin
                    n_free_ok = 1'b1;
                    n_tgt     = r_idx;
                end
            end
            S_APPLY: begin
                n_idx          = '0;
                n_rel_key      = {r_item.pid, r_item.dup_index};
                n_flag_earlier = 1'b1;
                n_min_ok       = 1'b0;
                n_have_pend    = 1'b0;
                if (r_hit || r_free_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = r_tgt;
                    wr_data = mod;
                end else begin
                    n_strobe           = 1'b1;
                    n_out              = '0;
                    n_out.kind         = KIND_FULL;
                    n_out.pid          = r_item.pid;
                    n_out.dup_index    = r_item.dup_index;
                    n_out.last         = 1'b1;
                end
            end
            S_REL_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
                if (rd_valid && rd_key <= r_rel_key && (!r_min_ok || rd_key < r_min_key)) begin
                    n_min_ok  = 1'b1;
                    n_min_idx = r_idx;
                    n_min_key = rd_key;
                end
            end
            S_REL_STEP: begin
                n_idx    = '0;
                n_min_ok = 1'b0;
                if (r_min_ok) begin
                    clr_en = 1'b1;
                    if (r_have_pend) begin
                        n_strobe = 1'b1;
                        n_out    = r_pend;
                    end
                    n_have_pend           = 1'b1;
                    n_pend                = '0;
                    n_pend.kind           = KIND_RELEASED;
                    n_pend.pid            = rd.pid;
                    n_pend.dup_index      = rd.dup;
                    n_pend.partial        = rd.flags[FLAG_PARTIAL] ||
                                            (r_flag_earlier && rd_key != r_rel_key);
                    n_pend.duplicate      = rd.flags[FLAG_DUP];
                    n_pend.missing_timing = !rd.flags[FLAG_TIMING];
                end else begin
                    n_have_pend = 1'b0;
                    n_strobe    = r_have_pend;
                    n_out       = r_pend;
                    n_out.last  = 1'b1;
                end
            end
            S_UNREG: begin
                n_idx          = r_idx + IDX_W'(1);
                n_flag_earlier = 1'b0;
                n_have_pend    = 1'b0;
                if (rd_valid && (rd.pending & bit_m) != 32'd0) begin
                    wr_en   = 1'b1;
                    wr_data = rd;
                    wr_data.pending             = rd.pending & ~bit_m;
                    wr_data.flags[FLAG_PARTIAL] = 1'b1;
                    if (wr_data.pending == 32'd0 && (!r_min_ok || r_rel_key <= rd_key)) begin
                        n_min_ok  = 1'b1;
                        n_rel_key = rd_key;
                    end
                end
                if (scan_end) begin
                    n_src    = r_src & ~bit_m;
                    n_min_ok = 1'b0;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    assign unreg_release = (r_state == S_UNREG) && scan_end &&
                           (r_min_ok || (rd_valid && (rd.pending & bit_m) != 32'd0 &&
                            (rd.pending & ~bit_m) == 32'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_src       <= '0;
            r_min_ok    <= 1'b0;
            r_have_pend <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_src       <= n_src;
            r_min_ok    <= n_min_ok;
            r_have_pend <= n_have_pend;
            r_hit       <= n_hit;
            r_free_ok   <= n_free_ok;
            r_idx       <= n_idx;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[r_min_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item         <= n_item;
        r_tgt          <= n_tgt;
        r_rel_key      <= n_rel_key;
        r_flag_earlier <= n_flag_earlier;
        r_min_idx      <= n_min_idx;
        r_min_key      <= n_min_key;
        r_pend         <= n_pend;
        r_out          <= n_out;
        if (wr_en) begin
            r_tab[wr_addr] <= wr_data;
        end
    end

endmodule

### rtl/pulse_completion_tracker_core.sv
// Top level: pulse completion tracker with a queued front end and a table sequencer.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; up to two items queue ahead of the
// table sequencer. Each result appears for one cycle under o_strobe, and the receiver cannot
// stall it. The sequencer reads one table entry per cycle. Register is answered straight from
// idle; touch, timing seen, mark partial and source done scan the whole table and then apply
// the item; a release adds one table scan and one release step per released pulse plus a
// closing scan; unregister scans the table once and then runs its release, if it has one.
// o_last marks an item's final result.
module pulse_completion_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_pulse_id,
    input  logic [7:0]  i_dup_index,
    input  logic [4:0]  i_source_slot,
    output logic        o_strobe,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_out_pulse_id,
    output logic [7:0]  o_out_dup_index,
    output logic        o_partial_flag,
    output logic        o_duplicate_flag,
    output logic        o_missing_timing_flag,
    output logic [4:0]  o_granted_slot,
    output logic        o_last
);
    import pct_pkg::*;

    t_item       item;
    t_queue_head head;
    logic        pop;
    t_result     res;

    assign item = '{opcode: i_opcode, pid: i_pulse_id, dup_index: i_dup_index,
                    source_slot: i_source_slot};

    pct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head)
    );

    pct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (res)
    );

    assign o_result_kind         = res.kind;
    assign o_out_pulse_id        = res.pid;
    assign o_out_dup_index       = res.dup_index;
    assign o_partial_flag        = res.partial;
    assign o_duplicate_flag      = res.duplicate;
    assign o_missing_timing_flag = res.missing_timing;
    assign o_granted_slot        = res.slot;
    assign o_last                = res.last;

endmodule

### tb/pulse_completion_tracker_core_test.sv
// Testbench: drives random and directed tracker items and checks every result against a model.
`timescale 1ns / 1ps
module pulse_completion_tracker_core_test;
    import pct_pkg::*;

    localparam int DRAIN_CYCLES = 4000;
    localparam int WATCHDOG_LIMIT = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_opcode = '0;
    logic [63:0] i_pulse_id = '0;
    logic [7:0]  i_dup_index = '0;
    logic [4:0]  i_source_slot = '0;
    logic        o_strobe;
    logic [1:0]  o_result_kind;
    logic [63:0] o_out_pulse_id;
    logic [7:0]  o_out_dup_index;
    logic        o_partial_flag;
    logic        o_duplicate_flag;
    logic        o_missing_timing_flag;
    logic [4:0]  o_granted_slot;
    logic        o_last;

    pulse_completion_tracker_core dut (.*);

    always #5 i_clk = ~i_clk;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches = 0;
    int      idle_pct = 0;
    int      stall_cycles = 0;

    bit          tbl_valid[TABLE_DEPTH];
    logic [63:0] tbl_id[TABLE_DEPTH];
    logic [7:0]  tbl_dup[TABLE_DEPTH];
    logic [31:0] tbl_pending[TABLE_DEPTH];
    logic [2:0]  tbl_flags[TABLE_DEPTH];
    logic [31:0] slots_used = '0;

    function automatic void enqueue(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic bit key_at_or_below(int i, logic [63:0] id, logic [7:0] dup);
        return tbl_id[i] < id || (tbl_id[i] == id && tbl_dup[i] <= dup);
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [63:0] id, logic [7:0] dup,
                                        logic [2:0] flags, logic [4:0] slot);
        t_result r;
        r.kind = kind;
        r.pid = id;
        r.dup_index = dup;
        r.partial = flags[FLAG_PARTIAL];
        r.duplicate = flags[FLAG_DUP];
        r.missing_timing = ~flags[FLAG_TIMING];
        r.slot = slot;
        r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic int find_or_add(logic [63:0] id, logic [7:0] dup);
        int free_idx;
        free_idx = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
                if (tbl_id[i] == id && tbl_dup[i] == dup) return i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (free_idx < 0) return -1;
        tbl_valid[free_idx] = 1;
        tbl_id[free_idx] = id;
        tbl_dup[free_idx] = dup;
        tbl_pending[free_idx] = slots_used;
        tbl_flags[free_idx] = '0;
        tbl_flags[free_idx][FLAG_DUP] = (dup != 0);
        return free_idx;
    endfunction

    function automatic int release_through(logic [63:0] id, logic [7:0] dup, bit flag_earlier);
        int best;
        int n;
        n = 0;
        forever begin
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i] && (best < 0 || key_at_or_below(i, tbl_id[best], tbl_dup[best])))
                    best = i;
            end
            if (best < 0 || !key_at_or_below(best, id, dup)) break;
            if (flag_earlier && !(tbl_id[best] == id && tbl_dup[best] == dup))
                tbl_flags[best][FLAG_PARTIAL] = 1'b1;
            push_result(KIND_RELEASED, tbl_id[best], tbl_dup[best], tbl_flags[best], '0);
            tbl_valid[best] = 0;
            n++;
        end
        return n;
    endfunction

    function automatic void track_item(t_item it);
        logic [7:0]  dup;
        logic [31:0] bitmask;
        int idx;
        int n;
        int top;
        bit granted;
        dup = it.dup_index;
        bitmask = (int'(it.source_slot) < SLOT_LIMIT) ? (32'd1 << it.source_slot) : 32'd0;
        n = 0;
        case (it.opcode)
            OP_TOUCH, OP_TIMING, OP_PARTIAL, OP_SRC_DONE: begin
                if (it.opcode == OP_TIMING) dup = '0;
                idx = find_or_add(it.pid, dup);
                if (idx < 0) begin
                    push_result(KIND_FULL, it.pid, dup, 3'b100, '0);
                    n = 1;
                end else if (it.opcode == OP_TIMING) begin
                    tbl_flags[idx][FLAG_TIMING] = 1'b1;
                end else if (it.opcode == OP_PARTIAL) begin
                    tbl_flags[idx][FLAG_PARTIAL] = 1'b1;
                end else if (it.opcode == OP_SRC_DONE) begin
                    tbl_pending[idx] &= ~bitmask;
                    if (tbl_pending[idx] == 0) n = release_through(it.pid, dup, 1);
                end
            end
            OP_REGISTER: begin
                granted = 0;
                for (int i = 0; i < SLOT_LIMIT; i++) begin
                    if (!granted && !slots_used[i]) begin
                        slots_used[i] = 1'b1;
                        push_result(KIND_GRANTED, '0, '0, 3'b100, 5'(i));
                        granted = 1;
                    end
                end
                if (!granted) push_result(KIND_NO_SLOT, '0, '0, 3'b100, '0);
                n = 1;
            end
            OP_UNREGISTER: begin
                top = -1;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && (tbl_pending[i] & bitmask) != 0) begin
                        tbl_flags[i][FLAG_PARTIAL] = 1'b1;
                        tbl_pending[i] &= ~bitmask;
                        if (tbl_pending[i] == 0 &&
                            (top < 0 || key_at_or_below(top, tbl_id[i], tbl_dup[i])))
                            top = i;
                    end
                end
                if (top >= 0) n = release_through(tbl_id[top], tbl_dup[top], 0);
                slots_used &= ~bitmask;
            end
            default: ;
        endcase
        if (n > 0) expected_results[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) track_item({i_opcode, i_pulse_id, i_dup_index, i_source_slot});
            if (!(start && busy) && pending_items.size() > 0 &&
                ($urandom_range(99) >= idle_pct)) begin
                t_item it;
                it = pending_items.pop_front();
                start <= 1'b1;
                i_opcode <= it.opcode;
                i_pulse_id <= it.pid;
                i_dup_index <= it.dup_index;
                i_source_slot <= it.source_slot;
            end else if (!(start && busy) && start) begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_kind, '0);
            end else begin
                t_result w;
                w = expected_results.pop_front();
                if (o_result_kind !== w.kind) report_mismatch("kind", o_result_kind, w.kind);
                if (o_out_pulse_id !== w.pid)
                    report_mismatch("pulse id", o_out_pulse_id, w.pid);
                if (o_out_dup_index !== w.dup_index)
                    report_mismatch("dup_index", o_out_dup_index, w.dup_index);
                if (o_partial_flag !== w.partial)
                    report_mismatch("partial", o_partial_flag, w.partial);
                if (o_duplicate_flag !== w.duplicate)
                    report_mismatch("duplicate", o_duplicate_flag, w.duplicate);
                if (o_missing_timing_flag !== w.missing_timing)
                    report_mismatch("missing_timing", o_missing_timing_flag, w.missing_timing);
                if (o_granted_slot !== w.slot)
                    report_mismatch("granted_slot", o_granted_slot, w.slot);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_item make_item(logic [2:0] op, logic [63:0] id, logic [7:0] dup,
                                        logic [4:0] slot);
        t_item it;
        it.opcode = op;
        it.pid = id;
        it.dup_index = dup;
        it.source_slot = slot;
        return it;
    endfunction

    function automatic logic [63:0] rand_id();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return 64'(100 + $urandom_range(11));
    endfunction

    function automatic void add_random_items(int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 15)
                enqueue(make_item(OP_TOUCH, rand_id(),
                    ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1)), '0));
            else if (sel < 30)
                enqueue(make_item(OP_TIMING, rand_id(), 8'($urandom), '0));
            else if (sel < 38)
                enqueue(make_item(OP_PARTIAL, rand_id(), 8'($urandom_range(1)),
                                  5'($urandom)));
            else if (sel < 75)
                enqueue(make_item(OP_SRC_DONE, rand_id(), 8'($urandom_range(1)),
                    ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(3))));
            else if (sel < 85)
                enqueue(make_item(OP_REGISTER, {$urandom, $urandom},
                                  8'($urandom), 5'($urandom)));
            else if (sel < 95)
                enqueue(make_item(OP_UNREGISTER, rand_id(), 8'($urandom),
                    ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3))));
            else
                enqueue(make_item(3'($urandom_range(7, 6)), {$urandom, $urandom},
                                  8'($urandom), 5'($urandom)));
        end
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        enqueue(make_item(OP_SRC_DONE, 64'd5, 8'd0, 5'd0));
        enqueue(make_item(OP_REGISTER, '0, '0, '0));
        enqueue(make_item(OP_REGISTER, '0, '0, '0));
        enqueue(make_item(OP_TOUCH, '1, 8'd255, 5'd31));
        enqueue(make_item(OP_TOUCH, 64'd0, 8'd0, 5'd0));
        enqueue(make_item(OP_TIMING, 64'd0, 8'd7, 5'd0));
        enqueue(make_item(OP_PARTIAL, 64'd9, 8'd1, 5'd0));
        enqueue(make_item(OP_SRC_DONE, 64'd9, 8'd1, 5'd31));
        enqueue(make_item(OP_SRC_DONE, 64'd9, 8'd1, 5'd0));
        enqueue(make_item(OP_SRC_DONE, 64'd9, 8'd1, 5'd1));
        enqueue(make_item(3'd6, '1, '1, '1));
        enqueue(make_item(3'd7, '0, '0, '0));
        enqueue(make_item(OP_UNREGISTER, '0, '0, 5'd1));
        enqueue(make_item(OP_UNREGISTER, '0, '0, 5'd0));
        for (int i = 0; i < 33; i++)
            enqueue(make_item(OP_REGISTER, '0, '0, '0));
        for (int i = 0; i < 33; i++)
            enqueue(make_item(OP_TOUCH, 64'(1000 + i), 8'(i), '0));
        enqueue(make_item(OP_UNREGISTER, '0, '0, 5'd31));
        for (int i = 0; i < 32; i++)
            enqueue(make_item(OP_UNREGISTER, '0, '0, 5'(i)));
        wait_drained();
        enqueue(make_item(OP_SRC_DONE, '1, 8'd255, 5'd0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 80 : (ph == 3) ? 18 : 0;
            add_random_items(20);
            enqueue(make_item(OP_SRC_DONE, '1, 8'd255, 5'd0));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
